/* design/mrq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrq_pkg
// Shared types for the mailbox ring queue: opcodes, status codes, controller
// states and the command word from controller to datapath.
// ----------------------------------------------------------------------------
package mrq_pkg;

	typedef enum logic [1:0] {
		OP_GET       = 2'd0,
		OP_PUT_BACK  = 2'd1,
		OP_PUT_FRONT = 2'd2,
		OP_FLUSH     = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_EXEC = 1'b1
	} ctrl_state_t;

	typedef struct packed {
		logic load;    // capture the incoming word
		logic commit;  // update queue state and load the result register
	} dp_cmd_t;

	localparam int CfgDataW = 32;
	localparam int CfgAddrW = 3;
	localparam int CapW     = 5;
	localparam logic [CapW-1:0] CapReset = 5'd16;
	localparam logic CAP_REG_SEL = 1'b0;  // paddr[2] for the capacity register

endpackage : mrq_pkg
`default_nettype wire

/* design/mrq_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrq_ctrl
// Controller: takes one word, waits for the result register to free up,
// then commits. Owns the output valid flag.
// ----------------------------------------------------------------------------
module mrq_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  wire logic            out_stall,
	output mrq_pkg::dp_cmd_t     cmd
);
	import mrq_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_nxt;
	logic        out_valid_q;
	logic        out_free;

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_nxt = S_EXEC;
				end
			end
			S_EXEC: begin
				if (out_free) begin
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_comb begin
		in_stall   = 1'b1;
		cmd.load   = 1'b0;
		cmd.commit = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			S_EXEC: begin
				cmd.commit = out_free;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule : mrq_ctrl
`default_nettype wire

/* design/mrq_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrq_dp
// Datapath: message RAM, read/write indices, held count and the result
// register. Acts on commands from the controller.
// ----------------------------------------------------------------------------
module mrq_dp #(
	parameter  int SLOTS        = 16,
	parameter  int MESSAGE_BITS = 32,
	localparam int CntW         = $clog2(SLOTS + 1)
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire mrq_pkg::dp_cmd_t          cmd,
	input  wire logic [1:0]                op,
	input  wire logic [MESSAGE_BITS-1:0]   message_in,
	input  wire logic [mrq_pkg::CapW-1:0]  capacity,
	output logic [1:0]                     status,
	output logic [MESSAGE_BITS-1:0]        message_out,
	output logic [CntW-1:0]                fill_level
);
	import mrq_pkg::*;

	localparam int IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CmpW = (CntW > CapW) ? CntW : CapW;
	localparam int NxtW = (IdxW + 1 > CntW) ? IdxW + 1 : CntW;

	logic [MESSAGE_BITS-1:0] mem [SLOTS];
	logic [MESSAGE_BITS-1:0] rdata_q;

	op_t                     op_q;
	logic [MESSAGE_BITS-1:0] msg_q;
	logic [IdxW-1:0]         rd_q;
	logic [IdxW-1:0]         wr_q;
	logic [CntW-1:0]         cnt_q;

	status_t                 status_q;
	logic [MESSAGE_BITS-1:0] msg_out_q;
	logic [CntW-1:0]         fill_q;

	// clamp the configured capacity to 1..SLOTS
	logic [CmpW-1:0] cap_w;
	logic [CmpW-1:0] cfg_w;
	logic [CntW-1:0] cap;
	logic [CntW-1:0] cap_m1;
	logic [NxtW-1:0] rd_inc;
	logic [NxtW-1:0] wr_inc;
	logic [IdxW-1:0] rd_next_get;
	logic [IdxW-1:0] rd_next_front;
	logic [IdxW-1:0] wr_next;
	logic            full;
	logic            empty;
	logic            mem_we;
	logic [IdxW-1:0] mem_wa;

	assign cfg_w = CmpW'(capacity);

	always_comb begin
		if (cfg_w == '0) begin
			cap_w = CmpW'(1);
		end else if (cfg_w > CmpW'(SLOTS)) begin
			cap_w = CmpW'(SLOTS);
		end else begin
			cap_w = cfg_w;
		end
	end

	assign cap    = cap_w[CntW-1:0];
	assign cap_m1 = cap - CntW'(1);
	assign full   = cnt_q >= cap;
	assign empty  = cnt_q == '0;

	assign rd_inc = NxtW'(rd_q) + NxtW'(1);
	assign wr_inc = NxtW'(wr_q) + NxtW'(1);

	assign rd_next_get   = (rd_inc >= NxtW'(cap)) ? '0 : rd_inc[IdxW-1:0];
	assign wr_next       = (wr_inc >= NxtW'(cap)) ? '0 : wr_inc[IdxW-1:0];
	assign rd_next_front = (rd_q == '0) ? cap_m1[IdxW-1:0]
	                                    : rd_q - IdxW'(1);

	assign mem_we = cmd.commit && !full
	                && (op_q == OP_PUT_BACK || op_q == OP_PUT_FRONT);
	assign mem_wa = (op_q == OP_PUT_FRONT) ? rd_next_front : wr_q;

	// RAM: one write port, one registered read port at the read index
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= msg_q;
		end
		rdata_q <= mem[rd_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= op_t'(op);
			msg_q <= message_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= '0;
			wr_q  <= '0;
			cnt_q <= '0;
		end else if (cmd.commit) begin
			case (op_q)
				OP_GET: begin
					if (!empty) begin
						rd_q  <= rd_next_get;
						cnt_q <= cnt_q - CntW'(1);
					end
				end
				OP_PUT_BACK: begin
					if (!full) begin
						wr_q  <= wr_next;
						cnt_q <= cnt_q + CntW'(1);
					end
				end
				OP_PUT_FRONT: begin
					if (!full) begin
						rd_q  <= rd_next_front;
						cnt_q <= cnt_q + CntW'(1);
					end
				end
				OP_FLUSH: begin
					rd_q  <= '0;
					wr_q  <= '0;
					cnt_q <= '0;
				end
				default: begin
					cnt_q <= cnt_q;
				end
			endcase
		end
	end

	// result register; fill level is the count after the operation
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status_q  <= ST_OK;
			msg_out_q <= '0;
			fill_q    <= cnt_q;
			case (op_q)
				OP_GET: begin
					if (empty) begin
						status_q <= ST_EMPTY;
					end else begin
						msg_out_q <= rdata_q;
						fill_q    <= cnt_q - CntW'(1);
					end
				end
				OP_PUT_BACK, OP_PUT_FRONT: begin
					if (full) begin
						status_q <= ST_FULL;
					end else begin
						fill_q <= cnt_q + CntW'(1);
					end
				end
				OP_FLUSH: begin
					fill_q <= '0;
				end
				default: begin
					status_q <= ST_OK;
				end
			endcase
		end
	end

	assign status      = status_q;
	assign message_out = msg_out_q;
	assign fill_level  = fill_q;

endmodule : mrq_dp
`default_nettype wire

/* design/mailbox_ring_queue_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mailbox_ring_queue_core
// Message mailbox in a ring buffer: get, put at back, put at front, flush,
// with an APB register for the queue capacity.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  --------+--------------------+----------------------------------------
//  in      | in_valid/in_stall  | op, message_in
//  out     | out_valid/out_stall| status, message_out, fill_level
//  cfg     | psel/penable/pready| paddr, pwrite, pwdata, prdata
//
//  Each word goes through a capture step, during which the RAM read at
//  the read index is registered, and then a commit step that updates the
//  indices and loads the result register.
//  Input is stalled during the commit wait; a stalled output holds the
//  commit back until the result register frees (it may free in that cycle).
//  Reset clears indices and count, and sets capacity to 16; no RAM clear.
// ----------------------------------------------------------------------------
module mailbox_ring_queue_core #(
	parameter  int SLOTS        = 16,
	parameter  int MESSAGE_BITS = 32,
	localparam int CntW         = $clog2(SLOTS + 1)
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [1:0]                    op,
	input  wire logic [MESSAGE_BITS-1:0]       message_in,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [1:0]                         status,
	output logic [MESSAGE_BITS-1:0]            message_out,
	output logic [CntW-1:0]                    fill_level,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [mrq_pkg::CfgAddrW-1:0]  paddr,
	input  wire logic [mrq_pkg::CfgDataW-1:0]  pwdata,
	output logic [mrq_pkg::CfgDataW-1:0]       prdata,
	output logic                               pready
);
	import mrq_pkg::*;

	dp_cmd_t         cmd;
	logic [CapW-1:0] cap_q;
	logic            cap_sel;

	assign pready  = 1'b1;
	assign cap_sel = paddr[2] == CAP_REG_SEL;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CapReset;
		end else if (psel && penable && pwrite && pready && cap_sel) begin
			cap_q <= pwdata[CapW-1:0];
		end
	end

	assign prdata = cap_sel ? CfgDataW'(cap_q) : '0;

	mrq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	mrq_dp #(
		.SLOTS        (SLOTS),
		.MESSAGE_BITS (MESSAGE_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.op          (op),
		.message_in  (message_in),
		.capacity    (cap_q),
		.status      (status),
		.message_out (message_out),
		.fill_level  (fill_level)
	);

endmodule : mailbox_ring_queue_core
`default_nettype wire
